@@ rtl/dtp_pkg.sv @@
// Shared types and constants for the DER TLV stream parser.
// Used by every module of the block; depends on nothing.

package dtp_pkg;

	localparam int LEN_FIELD_BYTES_DEF = 4;
	localparam int POSITION_BITS_DEF = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_UNSUP = 2'd2;
	localparam logic [1:0] ST_BADLEN = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] tag_byte;
		logic constructed;
		logic [2:0] header_length;
		logic [31:0] value_length;
		logic [31:0] value_offset;
	} out_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
		logic [31:0] next_offset;
	} queue_entry_t;

endpackage

@@ rtl/der_tlv_stream_parser.sv @@
// DER TLV stream parser top level: one buffer byte per transfer, one result
// per completed element or error. An element's final byte passes through a
// queue slot and then the result register before its result is shown.
// Throughput is one byte per cycle unless the queue fills or the output stalls.
// A four-entry queue separates byte intake from the walker and result register.
// Reset clears the position counter, queue pointers, walker state and valid flag.

module der_tlv_stream_parser #(
	parameter int LEN_FIELD_BYTES = dtp_pkg::LEN_FIELD_BYTES_DEF,
	parameter int POSITION_BITS = dtp_pkg::POSITION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  dtp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output dtp_pkg::out_item_t out_data
);

	logic push;
	logic full;
	logic not_empty;
	logic pop;
	dtp_pkg::queue_entry_t push_entry;
	dtp_pkg::queue_entry_t head;

	assign in_stall = full;
	assign push = in_valid && !full;

	dtp_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(in_data),
		.entry(push_entry)
	);

	dtp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(full),
		.not_empty(not_empty),
		.pop(pop),
		.head(head)
	);

	dtp_back #(
		.LEN_FIELD_BYTES(LEN_FIELD_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.entry_valid(not_empty),
		.entry(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

@@ rtl/dtp_front.sv @@
// Front part: tracks the byte position within the buffer and tags each byte
// with the saturated offset of the byte after it. Depends on dtp_pkg.

module dtp_front #(
	parameter int POSITION_BITS = dtp_pkg::POSITION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dtp_pkg::in_item_t     item,
	output dtp_pkg::queue_entry_t entry
);

	localparam int WIDE_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;

	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_inc;
	logic [WIDE_BITS-1:0] pos_wide;

	assign pos_inc = (pos_q == '1) ? pos_q : pos_q + POSITION_BITS'(1);
	assign pos_wide = WIDE_BITS'(pos_inc);

	always_comb begin
		entry.data_byte = item.data_byte;
		entry.last_byte = item.last_byte;
		if (pos_wide > WIDE_BITS'(32'hFFFF_FFFF)) begin
			entry.next_offset = 32'hFFFF_FFFF;
		end else begin
			entry.next_offset = pos_wide[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= item.last_byte ? '0 : pos_inc;
		end
	end

endmodule

@@ rtl/dtp_queue.sv @@
// Short queue between the front and back parts of the parser.
// Depends on dtp_pkg for the entry type and depth.

module dtp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dtp_pkg::queue_entry_t push_entry,
	output logic                  full,
	output logic                  not_empty,
	input  logic                  pop,
	output dtp_pkg::queue_entry_t head
);

	localparam int PTR_BITS = $clog2(dtp_pkg::QUEUE_DEPTH);

	dtp_pkg::queue_entry_t slots_q [dtp_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0] count_q;

	assign full = (count_q == (PTR_BITS+1)'(dtp_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_BITS+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_BITS+1)'(1);
			end
		end
	end

endmodule

@@ rtl/dtp_back.sv @@
// Back part: the TLV walking state machine and the result register.
// Consumes queue entries and depends on dtp_pkg.

module dtp_back #(
	parameter int LEN_FIELD_BYTES = dtp_pkg::LEN_FIELD_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  entry_valid,
	input  dtp_pkg::queue_entry_t entry,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output dtp_pkg::out_item_t    out_data
);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LEN0,
		PH_LENX,
		PH_VALUE,
		PH_DISCARD
	} phase_t;

	phase_t phase_q, phase_n;
	logic [7:0] tag_q, tag_n;
	logic [3:0] len_left_q, len_left_n, len_left_dec;
	logic [2:0] hdr_cnt_q, hdr_cnt_n, hdr_cnt_inc;
	logic [31:0] acc_q, acc_n;
	logic [31:0] val_left_q, val_left_n, val_left_dec;
	logic [31:0] val_start_q, val_start_n;
	logic [1:0] err;
	logic hdr_done;
	logic done_ok;
	logic [6:0] nb;
	logic res_valid;
	dtp_pkg::out_item_t res;
	logic advance;
	logic out_valid_q;
	dtp_pkg::out_item_t out_q;

	assign advance = !out_valid_q || !out_stall;
	assign pop = entry_valid && advance;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign nb = entry.data_byte[6:0];
	assign hdr_cnt_inc = (hdr_cnt_q == 3'd7) ? hdr_cnt_q : hdr_cnt_q + 3'd1;
	assign len_left_dec = (len_left_q != '0) ? len_left_q - 4'd1 : 4'd0;
	assign val_left_dec = (val_left_q != '0) ? val_left_q - 32'd1 : 32'd0;

	always_comb begin
		phase_n = phase_q;
		tag_n = tag_q;
		len_left_n = len_left_q;
		hdr_cnt_n = hdr_cnt_q;
		acc_n = acc_q;
		val_left_n = val_left_q;
		val_start_n = val_start_q;
		err = dtp_pkg::ST_OK;
		hdr_done = 1'b0;
		done_ok = 1'b0;
		unique case (phase_q)
			PH_TAG: begin
				tag_n = entry.data_byte;
				hdr_cnt_n = 3'd1;
				if (entry.last_byte) begin
					err = dtp_pkg::ST_TRUNC;
				end else if (entry.data_byte[4:0] == 5'h1F) begin
					err = dtp_pkg::ST_UNSUP;
				end else begin
					phase_n = PH_LEN0;
				end
			end
			PH_LEN0: begin
				hdr_cnt_n = hdr_cnt_inc;
				if (!entry.data_byte[7]) begin
					acc_n = {24'd0, entry.data_byte};
					hdr_done = 1'b1;
				end else if (nb == 7'd0) begin
					err = dtp_pkg::ST_UNSUP;
				end else if (nb > 7'(LEN_FIELD_BYTES)) begin
					err = dtp_pkg::ST_BADLEN;
				end else if (entry.last_byte) begin
					err = dtp_pkg::ST_TRUNC;
				end else begin
					len_left_n = nb[3:0];
					acc_n = '0;
					phase_n = PH_LENX;
				end
			end
			PH_LENX: begin
				hdr_cnt_n = hdr_cnt_inc;
				if (acc_q[31:24] != 8'd0) begin
					err = dtp_pkg::ST_BADLEN;
				end else begin
					acc_n = {acc_q[23:0], entry.data_byte};
					len_left_n = len_left_dec;
					if (len_left_dec == 4'd0) begin
						hdr_done = 1'b1;
					end else if (entry.last_byte) begin
						err = dtp_pkg::ST_TRUNC;
					end
				end
			end
			PH_VALUE: begin
				val_left_n = val_left_dec;
				if (val_left_dec == 32'd0) begin
					done_ok = 1'b1;
					phase_n = PH_TAG;
				end else if (entry.last_byte) begin
					err = dtp_pkg::ST_BADLEN;
				end
			end
			PH_DISCARD: begin
			end
			default: begin
			end
		endcase

		if (hdr_done) begin
			val_start_n = entry.next_offset;
			val_left_n = acc_n;
			if (acc_n == 32'd0) begin
				done_ok = 1'b1;
				phase_n = PH_TAG;
			end else if (entry.last_byte) begin
				err = dtp_pkg::ST_BADLEN;
			end else begin
				phase_n = PH_VALUE;
			end
		end

		res = '0;
		res_valid = 1'b0;
		if (err != dtp_pkg::ST_OK) begin
			res.status = err;
			res_valid = 1'b1;
			phase_n = PH_DISCARD;
		end else if (done_ok) begin
			res.status = dtp_pkg::ST_OK;
			res.tag_byte = tag_n;
			res.constructed = tag_n[5];
			res.header_length = hdr_cnt_n;
			res.value_length = acc_n;
			res.value_offset = val_start_n;
			res_valid = 1'b1;
		end

		if (entry.last_byte) begin
			phase_n = PH_TAG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q <= '0;
			len_left_q <= '0;
			hdr_cnt_q <= '0;
			acc_q <= '0;
			val_left_q <= '0;
			val_start_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				tag_q <= tag_n;
				len_left_q <= len_left_n;
				hdr_cnt_q <= hdr_cnt_n;
				acc_q <= acc_n;
				val_left_q <= val_left_n;
				val_start_q <= val_start_n;
			end
			if (advance) begin
				out_valid_q <= pop && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_q <= res;
		end
	end

endmodule

@@ rtl/dtp_checker.sv @@
// Port-level checks for the DER TLV stream parser and the bind that
// attaches them to der_tlv_stream_parser. Depends on dtp_pkg.

module dtp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input dtp_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result transfer dropped while stalled.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != dtp_pkg::ST_OK |->
		out_data.tag_byte == 8'd0 && out_data.header_length == 3'd0 &&
		out_data.value_length == 32'd0 && out_data.value_offset == 32'd0)
		else $error("Error result carries nonzero fields.");

	a_ok_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == dtp_pkg::ST_OK |->
		out_data.header_length >= 3'd2 && out_data.tag_byte[4:0] != 5'h1F)
		else $error("Good result has a malformed header.");

	a_ok_constructed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == dtp_pkg::ST_OK |->
		out_data.constructed == out_data.tag_byte[5])
		else $error("Constructed flag disagrees with the tag.");

endmodule

bind der_tlv_stream_parser dtp_checker u_dtp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);

@@ tb/sv/der_tlv_stream_parser_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for der_tlv_stream_parser: directed and random DER buffers,
// with every element record predicted in the testbench. Depends on rtl/dtp_pkg.sv
// and rtl/der_tlv_stream_parser.sv.

module der_tlv_stream_parser_test;

	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 9;
	localparam int RUN_LIMIT_NS = 2_000_000;
	localparam int PHASE_BYTES = 125;
	localparam int HOLD_OFF_CYCLES = 160;
	localparam int DRAIN_CYCLES = 20;
	localparam int LENGTH_OCTETS_MAX = dtp_pkg::LEN_FIELD_BYTES_DEF;
	localparam logic [4:0] HIGH_TAG_NUMBER = 5'h1F;
	localparam logic [7:0] LONG_FORM = 8'h80;
	localparam logic [3:0][7:0] SEND_IDLE = {8'd12, 8'd0, 8'd86, 8'd0};
	localparam logic [3:0][7:0] RECV_STALL = {8'd12, 8'd86, 8'd0, 8'd0};
	localparam dtp_pkg::out_item_t TRUNC_REC =
		'{dtp_pkg::ST_TRUNC, 8'd0, 1'b0, 3'd0, 32'd0, 32'd0};
	localparam dtp_pkg::out_item_t UNSUP_REC =
		'{dtp_pkg::ST_UNSUP, 8'd0, 1'b0, 3'd0, 32'd0, 32'd0};
	localparam dtp_pkg::out_item_t BADLEN_REC =
		'{dtp_pkg::ST_BADLEN, 8'd0, 1'b0, 3'd0, 32'd0, 32'd0};
	localparam dtp_pkg::out_item_t EMPTY_05_REC =
		'{dtp_pkg::ST_OK, 8'h05, 1'b0, 3'd2, 32'd0, 32'd2};

	typedef enum logic [2:0] {
		WALK_TAG,
		WALK_LEN_FIRST,
		WALK_LEN_MORE,
		WALK_VALUE,
		WALK_SKIP
	} walk_phase_t;

	typedef struct packed {
		dtp_pkg::in_item_t item;
		logic typed;
		dtp_pkg::out_item_t record;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	dtp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	dtp_pkg::out_item_t out_data;

	walk_phase_t walk_phase;
	logic [7:0] tag_held;
	logic [3:0] len_octets_left;
	logic [2:0] hdr_count;
	logic [31:0] len_acc;
	logic [31:0] value_left;
	logic [31:0] byte_pos;
	logic [31:0] value_pos;

	dtp_pkg::out_item_t pending_records[$];
	directed_row_t directed_rows[$];
	dtp_pkg::in_item_t buffer_bytes[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;

	der_tlv_stream_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic logic [31:0] sat_inc(input logic [31:0] p);
		return (p == '1) ? p : p + 32'd1;
	endfunction

	task automatic walk_byte(input dtp_pkg::in_item_t item, output bit produced,
			output dtp_pkg::out_item_t rec);
		logic [31:0] pos;
		logic [1:0] err;
		logic hdr_done;
		logic ok_done;
		pos = byte_pos;
		err = dtp_pkg::ST_OK;
		hdr_done = 1'b0;
		ok_done = 1'b0;
		byte_pos = sat_inc(pos);
		case (walk_phase)
			WALK_TAG: begin
				tag_held = item.data_byte;
				hdr_count = 3'd1;
				if (item.last_byte)
					err = dtp_pkg::ST_TRUNC;
				else if (item.data_byte[4:0] == HIGH_TAG_NUMBER)
					err = dtp_pkg::ST_UNSUP;
				else
					walk_phase = WALK_LEN_FIRST;
			end
			WALK_LEN_FIRST: begin
				if (hdr_count != 3'd7)
					hdr_count++;
				if (!item.data_byte[7]) begin
					len_acc = {24'd0, item.data_byte};
					hdr_done = 1'b1;
				end else if (item.data_byte[6:0] == 7'd0) begin
					err = dtp_pkg::ST_UNSUP;
				end else if (item.data_byte[6:0] > LENGTH_OCTETS_MAX) begin
					err = dtp_pkg::ST_BADLEN;
				end else if (item.last_byte) begin
					err = dtp_pkg::ST_TRUNC;
				end else begin
					len_octets_left = 4'(item.data_byte[6:0]);
					len_acc = '0;
					walk_phase = WALK_LEN_MORE;
				end
			end
			WALK_LEN_MORE: begin
				if (hdr_count != 3'd7)
					hdr_count++;
				if (len_acc[31:24] != 8'd0) begin
					err = dtp_pkg::ST_BADLEN;
				end else begin
					len_acc = {len_acc[23:0], item.data_byte};
					if (len_octets_left != 4'd0)
						len_octets_left--;
					if (len_octets_left == 4'd0)
						hdr_done = 1'b1;
					else if (item.last_byte)
						err = dtp_pkg::ST_TRUNC;
				end
			end
			WALK_VALUE: begin
				if (value_left != 32'd0)
					value_left--;
				if (value_left == 32'd0) begin
					ok_done = 1'b1;
					walk_phase = WALK_TAG;
				end else if (item.last_byte) begin
					err = dtp_pkg::ST_BADLEN;
				end
			end
			default: begin
			end
		endcase
		if (hdr_done) begin
			value_pos = sat_inc(pos);
			value_left = len_acc;
			if (len_acc == 32'd0) begin
				ok_done = 1'b1;
				walk_phase = WALK_TAG;
			end else if (item.last_byte) begin
				err = dtp_pkg::ST_BADLEN;
			end else begin
				walk_phase = WALK_VALUE;
			end
		end
		produced = 1'b0;
		rec = '0;
		if (err != dtp_pkg::ST_OK) begin
			rec.status = err;
			produced = 1'b1;
			walk_phase = WALK_SKIP;
		end else if (ok_done) begin
			rec = '{dtp_pkg::ST_OK, tag_held, tag_held[5], hdr_count, len_acc, value_pos};
			produced = 1'b1;
		end
		if (item.last_byte) begin
			walk_phase = WALK_TAG;
			byte_pos = '0;
		end
	endtask

	task automatic send_byte(input dtp_pkg::in_item_t item, input logic typed = 1'b0,
			input dtp_pkg::out_item_t typed_rec = '0);
		bit produced;
		dtp_pkg::out_item_t rec;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		walk_byte(item, produced, rec);
		if (typed)
			pending_records.push_back(typed_rec);
		else if (produced)
			pending_records.push_back(rec);
		@(negedge clk);
	endtask

	task automatic add_row(input logic [7:0] data, input logic last, input logic typed = 1'b0,
			input dtp_pkg::out_item_t record = '0);
		directed_rows.push_back('{'{data, last}, typed, record});
	endtask

	task automatic make_buffer();
		int elements;
		int vlen;
		int octets;
		int kind;
		int keep;
		logic [7:0] tag;
		kind = $urandom_range(99);
		elements = $urandom_range(1, 4);
		buffer_bytes.delete();
		for (int e = 0; e < elements; e++) begin
			do
				tag = 8'($urandom);
			while (tag[4:0] == HIGH_TAG_NUMBER);
			vlen = ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(6);
			buffer_bytes.push_back('{tag, 1'b0});
			if (vlen < 128 && $urandom_range(1) == 1) begin
				buffer_bytes.push_back('{8'(vlen), 1'b0});
			end else begin
				octets = $urandom_range(vlen > 255 ? 2 : 1, LENGTH_OCTETS_MAX);
				buffer_bytes.push_back('{LONG_FORM | 8'(octets), 1'b0});
				for (int i = octets - 1; i >= 0; i--)
					buffer_bytes.push_back('{8'(vlen >> (8 * i)), 1'b0});
			end
			repeat (vlen)
				buffer_bytes.push_back('{8'($urandom), 1'b0});
		end
		if (kind < 8) begin
			keep = $urandom_range(1, buffer_bytes.size());
			while (buffer_bytes.size() > keep)
				void'(buffer_bytes.pop_back());
		end else if (kind < 14) begin
			buffer_bytes[$urandom_range(buffer_bytes.size() - 1)].data_byte = 8'($urandom);
		end else if (kind < 17) begin
			buffer_bytes.delete();
			repeat ($urandom_range(1, 8))
				buffer_bytes.push_back('{8'($urandom), 1'b0});
		end else if (kind < 19) begin
			buffer_bytes[1].data_byte = ($urandom_range(2) == 0) ? LONG_FORM
				: LONG_FORM | 8'($urandom_range(LENGTH_OCTETS_MAX + 1, 127));
		end else if (kind < 20) begin
			buffer_bytes[0].data_byte[4:0] = HIGH_TAG_NUMBER;
		end
		buffer_bytes[$].last_byte = 1'b1;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_record(input dtp_pkg::out_item_t got);
		dtp_pkg::out_item_t want;
		if (pending_records.size() == 0) begin
			flag_mismatch("record with none pending, tag", 32'(got.tag_byte), 32'd0);
		end else begin
			want = pending_records.pop_front();
			if (got.status !== want.status)
				flag_mismatch("status", 32'(got.status), 32'(want.status));
			if (got.tag_byte !== want.tag_byte)
				flag_mismatch("tag_byte", 32'(got.tag_byte), 32'(want.tag_byte));
			if (got.constructed !== want.constructed)
				flag_mismatch("constructed", 32'(got.constructed), 32'(want.constructed));
			if (got.header_length !== want.header_length)
				flag_mismatch("header_length", 32'(got.header_length), 32'(want.header_length));
			if (got.value_length !== want.value_length)
				flag_mismatch("value_length", got.value_length, want.value_length);
			if (got.value_offset !== want.value_offset)
				flag_mismatch("value_offset", got.value_offset, want.value_offset);
		end
	endtask

	// The receiver holds off on request for a counted stretch, otherwise stalls at random.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			out_stall <= 1'b1;
			hold_request = hold_request - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			check_record(out_data);
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int phase_bytes;
		walk_phase = WALK_TAG;
		tag_held = '0;
		len_octets_left = '0;
		hdr_count = '0;
		len_acc = '0;
		value_left = '0;
		byte_pos = '0;
		value_pos = '0;

		add_row(8'h30, 1'b1, 1'b1, TRUNC_REC);
		add_row(8'h1F, 1'b0, 1'b1, UNSUP_REC);
		add_row(8'h55, 1'b1);
		add_row(8'h05, 1'b0);
		add_row(8'h00, 1'b1, 1'b1, EMPTY_05_REC);
		add_row(8'h30, 1'b0);
		add_row(8'h80, 1'b1, 1'b1, UNSUP_REC);
		add_row(8'h04, 1'b0);
		add_row(8'h85, 1'b1, 1'b1, BADLEN_REC);
		add_row(8'h02, 1'b0);
		add_row(8'h81, 1'b1, 1'b1, TRUNC_REC);
		add_row(8'h02, 1'b0);
		add_row(8'h83, 1'b0);
		add_row(8'h01, 1'b1, 1'b1, TRUNC_REC);
		add_row(8'h30, 1'b0);
		add_row(8'h84, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'hFF, 1'b1, 1'b1, BADLEN_REC);
		add_row(8'hE3, 1'b0);
		add_row(8'h82, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h02, 1'b0);
		add_row(8'h11, 1'b0);
		add_row(8'h22, 1'b1);

		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].record);

		// Back-to-back empty elements while the receiver holds off fill the block up.
		hold_request = HOLD_OFF_CYCLES;
		for (int i = 0; i < 24; i++) begin
			send_byte('{8'($urandom_range(30)), 1'b0});
			send_byte('{8'h00, i == 23});
		end

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = int'(SEND_IDLE[p]);
			stall_pct = int'(RECV_STALL[p]);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				make_buffer();
				foreach (buffer_bytes[i])
					send_byte(buffer_bytes[i]);
				phase_bytes += buffer_bytes.size();
			end
		end
		in_valid <= 1'b0;
		stall_pct = 0;

		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
